[rtl/dpoc_pkg.sv]
// ----------------------------------------------------------------------------
// dpoc_pkg
// Shared types, register indexes and constants of the debounced proximity
// object counter.
// ----------------------------------------------------------------------------
package dpoc_pkg;

  // Width of the object counter held inside the block.
  localparam int unsigned COUNT_BITS_DEF = 16;

  // Width of the reported object count.
  localparam int unsigned OBJECT_COUNT_W = 16;

  // Configuration port geometry.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 22;

  // Debounce constants.
  localparam logic [2:0] QUALIFY_RUN  = 3'd5;
  localparam logic [2:0] HIGH_RUN_MAX = 3'd7;
  localparam logic [7:0] FAIL_MAX     = 8'd255;

  // Register reset values.
  localparam logic [15:0] THRESHOLD_RST        = 16'd0;
  localparam logic [3:0]  RELEASE_READS_RST    = 4'd2;
  localparam logic [7:0]  FAIL_LIMIT_RST       = 8'd10;
  localparam logic [19:0] DECREASE_TIMEOUT_RST = 20'd20000;
  localparam logic [21:0] SLEEP_TIMEOUT_RST    = 22'd1800000;

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_READ  = 2'd1,
    MODE_CLEAR = 2'd2
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD        = 3'd0,
    CFG_RELEASE_READS    = 3'd1,
    CFG_FAIL_LIMIT       = 3'd2,
    CFG_DECREASE_TIMEOUT = 3'd3,
    CFG_SLEEP_TIMEOUT    = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0] threshold;
    logic [3:0]  release_reads;
    logic [7:0]  fail_limit;
    logic [19:0] decrease_timeout;
    logic [21:0] sleep_timeout;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic        read_ok;
    logic [15:0] proximity;
  } item_t;

  typedef struct packed {
    logic [OBJECT_COUNT_W-1:0] object_count;
    logic                      object_present;
    logic                      read_error;
    logic                      decrease_pending;
    logic                      sleep_request;
  } result_t;

endpackage

[rtl/dpoc_stream_if.sv]
// ----------------------------------------------------------------------------
// dpoc_stream_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface dpoc_stream_if #(
  parameter type payload_t = logic [0:0]
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

[rtl/debounced_proximity_object_counter_core.sv]
// ----------------------------------------------------------------------------
// debounced_proximity_object_counter_core
// Debounced proximity object counter with tick, read and clear transactions.
// ----------------------------------------------------------------------------
// Results: an accepted transaction is held in the input register, and its
// result is then captured in the result register and offered until taken.
// Throughput: one transaction per cycle while results are taken; the input
// register, state update and result register each take one item per clock.
// Reset: asynchronous, active low; registers take their documented defaults,
// the state takes its reset values, and both stages of the pipeline are emptied.
// ----------------------------------------------------------------------------
module debounced_proximity_object_counter_core #(
  parameter int unsigned COUNT_BITS = dpoc_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [dpoc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [dpoc_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  dpoc_stream_if.sink                     item_i,
  dpoc_stream_if.source                   result_o
);
  import dpoc_pkg::*;

  // The block is a two-stage pipeline. Stage one registers the incoming
  // transaction. Stage two applies it to the counter state in a single
  // pass and captures the state after the update in the result register.
  // Because the state is written in the same cycle that the result is
  // captured, the next item in stage one always sees an up-to-date state,
  // so back-to-back transactions need no forwarding.

  cfg_t    cfg;
  item_t   s1_item_q;
  logic    s1_valid_q;
  result_t step_result;
  result_t out_q;
  logic    out_valid_q;
  logic    advance;
  logic    step;

  dpoc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Stage two moves whenever the result register is empty or being drained.
  assign advance = !out_valid_q || result_o.ready;
  // An item is processed when stage one holds one and it can move on.
  assign step    = s1_valid_q && advance;

  // Stage one takes a new transaction when empty or when it empties this cycle,
  // so a waiting result stops the input side only while stage one is full.
  assign item_i.ready = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (item_i.ready) begin
      s1_valid_q <= item_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_i.valid && item_i.ready) begin
      s1_item_q <= item_i.payload;
    end
  end

  dpoc_state #(
    .COUNT_BITS (COUNT_BITS)
  ) u_state (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (s1_item_q),
    .cfg_i    (cfg),
    .result_o (step_result)
  );

  // Result register: one result per processed transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= step_result;
    end
  end

  assign result_o.valid   = out_valid_q;
  assign result_o.payload = out_q;

  // An empty input stage must always be able to take a transaction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> item_i.ready)
    else $error("input stage empty but not ready");

  // A held item in stage one must not change while it waits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !advance) |=> (s1_valid_q && $stable(s1_item_q)))
    else $error("stalled item in stage one was lost or altered");

  // A result appears only after stage one held an item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_valid_q))
    else $error("result produced without a processed item");

  // A present object and an armed decrease timer exclude each other.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.object_present && out_q.decrease_pending))
    else $error("decrease timer armed while an object is present");

endmodule

[rtl/dpoc_cfg.sv]
// ----------------------------------------------------------------------------
// dpoc_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module dpoc_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [dpoc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [dpoc_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output dpoc_pkg::cfg_t                  cfg_o
);
  import dpoc_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold        <= THRESHOLD_RST;
      cfg_q.release_reads    <= RELEASE_READS_RST;
      cfg_q.fail_limit       <= FAIL_LIMIT_RST;
      cfg_q.decrease_timeout <= DECREASE_TIMEOUT_RST;
      cfg_q.sleep_timeout    <= SLEEP_TIMEOUT_RST;
    end else if (cfg_we_i) begin
      // Writes to unused indexes are dropped.
      case (cfg_idx_e'(cfg_idx_i))
        CFG_THRESHOLD:        cfg_q.threshold        <= cfg_wdata_i[15:0];
        CFG_RELEASE_READS:    cfg_q.release_reads    <= cfg_wdata_i[3:0];
        CFG_FAIL_LIMIT:       cfg_q.fail_limit       <= cfg_wdata_i[7:0];
        CFG_DECREASE_TIMEOUT: cfg_q.decrease_timeout <= cfg_wdata_i[19:0];
        CFG_SLEEP_TIMEOUT:    cfg_q.sleep_timeout    <= cfg_wdata_i[21:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/dpoc_state.sv]
// ----------------------------------------------------------------------------
// dpoc_state
// Counter state and its single-pass update for one tick, read or clear.
// ----------------------------------------------------------------------------
module dpoc_state #(
  parameter int unsigned COUNT_BITS = dpoc_pkg::COUNT_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  dpoc_pkg::item_t   item_i,
  input  dpoc_pkg::cfg_t    cfg_i,
  output dpoc_pkg::result_t result_o
);
  import dpoc_pkg::*;

  logic [COUNT_BITS-1:0] count_q, count_d;
  logic                  present_q, present_d;
  logic [2:0]            high_run_q, high_run_d;
  logic [3:0]            low_left_q, low_left_d;
  logic [7:0]            fail_run_q, fail_run_d;
  logic                  error_q, error_d;
  logic                  armed_q, armed_d;
  logic [19:0]           dec_timer_q, dec_timer_d;
  logic [21:0]           sleep_timer_q, sleep_timer_d;
  logic                  sleep_q, sleep_d;

  logic [2:0]                       run_first;
  logic [COUNT_BITS+OBJECT_COUNT_W-1:0] count_ext;

  function automatic logic [2:0] run_inc(input logic [2:0] run);
    return (run == HIGH_RUN_MAX) ? run : run + 3'd1;
  endfunction

  assign run_first = run_inc(high_run_q);

  always_comb begin
    count_d       = count_q;
    present_d     = present_q;
    high_run_d    = high_run_q;
    low_left_d    = low_left_q;
    fail_run_d    = fail_run_q;
    error_d       = error_q;
    armed_d       = armed_q;
    dec_timer_d   = dec_timer_q;
    sleep_timer_d = sleep_timer_q;
    sleep_d       = sleep_q;

    case (mode_e'(item_i.mode))
      MODE_TICK: begin
        if (armed_q) begin
          if (dec_timer_q == '0) begin
            if (count_q != '0) begin
              count_d = count_q - 1'b1;
            end
            armed_d = 1'b0;
          end else begin
            dec_timer_d = dec_timer_q - 20'd1;
          end
        end
        if (sleep_timer_q == '0) begin
          sleep_d = 1'b1;
        end else begin
          sleep_timer_d = sleep_timer_q - 22'd1;
        end
      end
      MODE_READ: begin
        if (!item_i.read_ok) begin
          if (fail_run_q != FAIL_MAX) begin
            fail_run_d = fail_run_q + 8'd1;
          end
          if (fail_run_d == cfg_i.fail_limit) begin
            error_d = 1'b1;
          end
        end else begin
          fail_run_d = '0;
          error_d    = 1'b0;
          if (item_i.proximity > cfg_i.threshold) begin
            armed_d    = 1'b0;
            low_left_d = cfg_i.release_reads;
            if (!present_q) begin
              // The run advances by two; the middle value is the qualifying test.
              if (run_first == QUALIFY_RUN) begin
                present_d     = 1'b1;
                sleep_timer_d = cfg_i.sleep_timeout;
                count_d       = count_q + 1'b1;
              end
              high_run_d = (run_first <= QUALIFY_RUN) ? run_inc(run_first) : run_first;
            end
          end else begin
            high_run_d = '0;
            if (present_q && (low_left_q != '0)) begin
              low_left_d = low_left_q - 4'd1;
              if (low_left_q == 4'd1) begin
                present_d = 1'b0;
                if (count_q[0]) begin
                  armed_d     = 1'b1;
                  dec_timer_d = cfg_i.decrease_timeout;
                end else begin
                  armed_d = 1'b0;
                end
              end
            end
          end
        end
      end
      MODE_CLEAR: begin
        count_d    = '0;
        high_run_d = '0;
        fail_run_d = '0;
        armed_d    = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q       <= '0;
      present_q     <= 1'b0;
      high_run_q    <= '0;
      low_left_q    <= RELEASE_READS_RST;
      fail_run_q    <= '0;
      error_q       <= 1'b0;
      armed_q       <= 1'b0;
      dec_timer_q   <= '0;
      sleep_timer_q <= SLEEP_TIMEOUT_RST;
      sleep_q       <= 1'b0;
    end else if (step_i) begin
      count_q       <= count_d;
      present_q     <= present_d;
      high_run_q    <= high_run_d;
      low_left_q    <= low_left_d;
      fail_run_q    <= fail_run_d;
      error_q       <= error_d;
      armed_q       <= armed_d;
      dec_timer_q   <= dec_timer_d;
      sleep_timer_q <= sleep_timer_d;
      sleep_q       <= sleep_d;
    end
  end

  // Report the low bits of the count, zero-extended when the counter is narrow.
  assign count_ext = {{OBJECT_COUNT_W{1'b0}}, count_d};

  assign result_o.object_count     = count_ext[OBJECT_COUNT_W-1:0];
  assign result_o.object_present   = present_d;
  assign result_o.read_error       = error_d;
  assign result_o.decrease_pending = armed_d;
  assign result_o.sleep_request    = sleep_d;

endmodule
